// ===== sv/xdbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdbt_pkg
// Shared types and constants for the XOR distance bucket table.
// ----------------------------------------------------------------------------
package xdbt_pkg;

  // Fixed field widths of the stream payload
  localparam int IdW       = 64;
  localparam int BktW      = 6;
  localparam int StatusW   = 3;
  localparam int OutDataW  = 72;  // bucket_index + entry_id, padded to bytes

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_OWN_ID   = 3'd2,
    ST_MATCH    = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  // Request opcodes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FIND   = 1'b1
  } opcode_t;

  // Memory strobes from the sequencer to the storage
  typedef struct packed {
    logic fill_rd;
    logic fill_wr;
    logic ent_rd;
    logic ent_wr;
  } mem_ctl_t;

endpackage

// ===== sv/xdbt_lzc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdbt_lzc
// Two-step leading zero counter over a left-aligned 64-bit distance.
// Step one counts inside each byte, step two picks the top nonzero byte.
// ----------------------------------------------------------------------------
module xdbt_lzc
  import xdbt_pkg::*;
(
  input  logic            clk,
  input  logic            start,
  input  logic [IdW-1:0]  word,
  output logic            zero,
  output logic [BktW-1:0] cnt
);

  localparam int NGrp = IdW / 8;

  logic [NGrp-1:0] nz_r;
  logic [2:0]      glz_r [NGrp];
  logic [2:0]      sel;

  // Leading zeros of a nonzero byte
  function automatic logic [2:0] lz8(input logic [7:0] v);
    logic [2:0] n;
    logic       hit;
    n   = 3'd0;
    hit = 1'b0;
    for (int b = 7; b >= 0; b--) begin
      if (v[b]) begin
        hit = 1'b1;
      end else if (!hit) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

  // Per-byte flags and counts, byte 0 is the most significant
  always_ff @(posedge clk) begin
    if (start) begin
      for (int g = 0; g < NGrp; g++) begin
        nz_r[g]  <= |word[IdW-1-8*g -: 8];
        glz_r[g] <= lz8(word[IdW-1-8*g -: 8]);
      end
    end
  end

  // Topmost nonzero byte
  always_comb begin
    sel = 3'd0;
    for (int g = NGrp - 1; g >= 0; g--) begin
      if (nz_r[g]) begin
        sel = 3'(g);
      end
    end
  end

  assign zero = ~|nz_r;
  assign cnt  = {sel, glz_r[sel]};

endmodule

// ===== sv/xdbt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdbt_store
// Entry memory (one row of slots per bucket) and bucket fill-count memory.
// Fill counts carry a valid bit per bucket so reset empties every bucket.
// ----------------------------------------------------------------------------
module xdbt_store
  import xdbt_pkg::*;
#(
  parameter int ID_WIDTH           = 64,
  parameter int ENTRIES_PER_BUCKET = 3,
  localparam int EntDepth = ID_WIDTH * ENTRIES_PER_BUCKET,
  localparam int EntAw    = $clog2(EntDepth),
  localparam int BktAw    = $clog2(ID_WIDTH),
  localparam int FillW    = $clog2(ENTRIES_PER_BUCKET + 1)
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  mem_ctl_t            ctl,
  input  logic [BktAw-1:0]    fill_addr,
  input  logic [FillW-1:0]    fill_wdata,
  output logic [FillW-1:0]    fill_rdata,
  input  logic [EntAw-1:0]    ent_addr,
  input  logic [ID_WIDTH-1:0] ent_wdata,
  output logic [ID_WIDTH-1:0] ent_rdata
);

  logic [ID_WIDTH-1:0] ent_mem [EntDepth];
  logic [FillW-1:0]    fill_mem [ID_WIDTH];
  logic [ID_WIDTH-1:0] fill_vld_r;
  logic [FillW-1:0]    fill_q_r;
  logic                fill_vld_q_r;
  logic [ID_WIDTH-1:0] ent_q_r;

  // Entry memory, one port
  always_ff @(posedge clk) begin
    if (ctl.ent_wr) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    if (ctl.ent_rd) begin
      ent_q_r <= ent_mem[ent_addr];
    end
  end

  // Fill-count memory
  always_ff @(posedge clk) begin
    if (ctl.fill_wr) begin
      fill_mem[fill_addr] <= fill_wdata;
    end
    if (ctl.fill_rd) begin
      fill_q_r <= fill_mem[fill_addr];
    end
  end

  // Bucket valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_vld_r   <= '0;
      fill_vld_q_r <= 1'b0;
    end else begin
      if (ctl.fill_wr) begin
        fill_vld_r[fill_addr] <= 1'b1;
      end
      if (ctl.fill_rd) begin
        fill_vld_q_r <= fill_vld_r[fill_addr];
      end
    end
  end

  assign fill_rdata = fill_vld_q_r ? fill_q_r : '0;
  assign ent_rdata  = ent_q_r;

endmodule

// ===== sv/xor_distance_bucket_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_distance_bucket_table
// Routing table of node IDs, bucketed by leading zeros of the XOR distance
// to the local ID. Insert appends to the bucket while it has room; find
// returns the matching entry or every entry of the bucket, newest first.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake            Payload
//  in_      in   in_tvalid/tready     tuser: opcode; tdata: node_id
//  out_     out  out_tvalid/tready    tuser: status; tdata: bucket_index,
//                                     entry_id; tlast: last
//  cfg_     in   cfg_valid/ready      cfg_data: own node ID
//
//  One request at a time. An own-ID result is emitted from state S_LZB,
//  insert and empty-bucket results from S_FILL; a find reads the bucket's
//  slots one at a time through the single entry-memory port, in a search
//  pass and, without a match, a listing pass. The next request is taken in
//  the cycle after the last result is registered.
//  Reset clears fill counts at once through per-bucket valid bits.
//  A stalled result holds the sequencer; the output register lets one
//  result wait while the next request is taken.
// ----------------------------------------------------------------------------
module xor_distance_bucket_table
  import xdbt_pkg::*;
#(
  parameter int ID_WIDTH           = 64,
  parameter int ENTRIES_PER_BUCKET = 3
)
(
  input  logic                clk,
  input  logic                rst_n,
  // request stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IdW-1:0]      in_tdata,   // [63:0] node_id
  input  logic [0:0]          in_tuser,   // [0] opcode
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [5:0] bucket_index, [69:6] entry_id
  output logic [StatusW-1:0]  out_tuser,  // [2:0] status
  output logic                out_tlast,
  // local ID write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IdW-1:0]      cfg_data
);

  localparam int EntDepth = ID_WIDTH * ENTRIES_PER_BUCKET;
  localparam int EntAw    = $clog2(EntDepth);
  localparam int BktAw    = $clog2(ID_WIDTH);
  localparam int FillW    = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int SlotW    = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LZA,
    S_LZB,
    S_FILL,
    S_SRD,
    S_SCMP
  } state_t;

  state_t              state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic [BktW-1:0]     bkt_r, bkt_nxt;
  logic [FillW-1:0]    fill_r, fill_nxt;
  logic [SlotW-1:0]    slot_r, slot_nxt;
  logic                pass_r, pass_nxt;
  logic [IdW-1:0]      local_r;

  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OutDataW-1:0] out_tdata_r, out_tdata_nxt;
  logic [StatusW-1:0]  out_tuser_r, out_tuser_nxt;
  logic                out_tlast_r, out_tlast_nxt;

  logic                free;
  logic                emit;
  status_t             emit_status;
  logic [BktW-1:0]     emit_bkt;
  logic [IdW-1:0]      emit_entry;
  logic                emit_last;

  logic [ID_WIDTH-1:0] xor_dist;
  logic [IdW-1:0]      dist_al;
  logic                lz_start;
  logic                lz_zero;
  logic [BktW-1:0]     lz_cnt;

  mem_ctl_t            ctl;
  logic [BktAw-1:0]    fill_addr;
  logic [FillW-1:0]    fill_wdata;
  logic [FillW-1:0]    fill_rdata;
  logic [SlotW-1:0]    ent_slot;
  logic [EntAw-1:0]    ent_addr;
  logic [ID_WIDTH-1:0] ent_rdata;

  // Distance, left-aligned so bit ID_WIDTH-1 sits at the top
  assign xor_dist = id_r ^ local_r[ID_WIDTH-1:0];
  assign dist_al  = IdW'(xor_dist) << (IdW - ID_WIDTH);

  xdbt_lzc u_lzc (
    .clk   (clk),
    .start (lz_start),
    .word  (dist_al),
    .zero  (lz_zero),
    .cnt   (lz_cnt)
  );

  // Memory addressing: bucket row plus slot
  assign fill_addr  = (state_r == S_LZB) ? lz_cnt[BktAw-1:0] : bkt_r[BktAw-1:0];
  assign fill_wdata = fill_rdata + FillW'(1);
  assign ent_slot   = (state_r == S_FILL) ? SlotW'(fill_rdata) : slot_r;
  assign ent_addr   = EntAw'(bkt_r * ENTRIES_PER_BUCKET) + EntAw'(ent_slot);

  xdbt_store #(
    .ID_WIDTH           (ID_WIDTH),
    .ENTRIES_PER_BUCKET (ENTRIES_PER_BUCKET)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .fill_addr  (fill_addr),
    .fill_wdata (fill_wdata),
    .fill_rdata (fill_rdata),
    .ent_addr   (ent_addr),
    .ent_wdata  (id_r),
    .ent_rdata  (ent_rdata)
  );

  assign free = !out_tvalid_r || out_tready;

  // Sequencer next state
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    bkt_nxt     = bkt_r;
    fill_nxt    = fill_r;
    slot_nxt    = slot_r;
    pass_nxt    = pass_r;
    lz_start    = 1'b0;
    ctl         = '0;
    emit        = 1'b0;
    emit_status = ST_INSERTED;
    emit_bkt    = bkt_r;
    emit_entry  = '0;
    emit_last   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser[0];
          id_nxt    = in_tdata[ID_WIDTH-1:0];
          state_nxt = S_LZA;
        end
      end
      S_LZA: begin
        lz_start  = 1'b1;
        state_nxt = S_LZB;
      end
      S_LZB: begin
        if (lz_zero) begin
          // own ID: no bucket
          if (free) begin
            emit        = 1'b1;
            emit_status = ST_OWN_ID;
            emit_bkt    = '0;
            state_nxt   = S_IDLE;
          end
        end else begin
          bkt_nxt     = lz_cnt;
          ctl.fill_rd = 1'b1;
          state_nxt   = S_FILL;
        end
      end
      S_FILL: begin
        fill_nxt = fill_rdata;
        if (op_r == OP_INSERT) begin
          if (free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (fill_rdata < FillW'(ENTRIES_PER_BUCKET)) begin
              ctl.ent_wr  = 1'b1;
              ctl.fill_wr = 1'b1;
              emit_status = ST_INSERTED;
            end else begin
              emit_status = ST_FULL;
            end
          end
        end else if (fill_rdata == '0) begin
          if (free) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
            state_nxt   = S_IDLE;
          end
        end else begin
          slot_nxt  = SlotW'(fill_rdata - FillW'(1));
          pass_nxt  = 1'b0;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        ctl.ent_rd = 1'b1;
        state_nxt  = S_SCMP;
      end
      S_SCMP: begin
        if (!pass_r) begin
          // search pass, newest first
          if (ent_rdata == id_r) begin
            if (free) begin
              emit        = 1'b1;
              emit_status = ST_MATCH;
              emit_entry  = IdW'(id_r);
              state_nxt   = S_IDLE;
            end
          end else if (slot_r == '0) begin
            pass_nxt  = 1'b1;
            slot_nxt  = SlotW'(fill_r - FillW'(1));
            state_nxt = S_SRD;
          end else begin
            slot_nxt  = slot_r - SlotW'(1);
            state_nxt = S_SRD;
          end
        end else if (free) begin
          // listing pass
          emit        = 1'b1;
          emit_status = ST_ENTRY;
          emit_entry  = IdW'(ent_rdata);
          emit_last   = (slot_r == '0);
          if (slot_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            slot_nxt  = slot_r - SlotW'(1);
            state_nxt = S_SRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    if (emit) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {(OutDataW - IdW - BktW)'(0), emit_entry, emit_bkt};
      out_tuser_nxt  = emit_status;
      out_tlast_nxt  = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      local_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid) begin
        local_r <= cfg_data;
      end
    end
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    bkt_r       <= bkt_nxt;
    fill_r      <= fill_nxt;
    slot_r      <= slot_nxt;
    pass_r      <= pass_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== sv/xdbt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xdbt_checker
// Port-level checks on the bucket table, bound to the top level.
// ----------------------------------------------------------------------------
module xdbt_checker
  import xdbt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic [StatusW-1:0]  out_tuser,
  input logic                out_tlast
);

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // One request in flight: no new request the cycle after one is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in flight");

  // Own ID gives bucket 0, no entry, single result
  a_own_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_OWN_ID |->
      out_tlast && out_tdata == '0)
    else $error("own-ID result malformed");

  // Single-result statuses close the request
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_INSERTED || out_tuser == ST_FULL ||
      out_tuser == ST_EMPTY || out_tuser == ST_MATCH) |-> out_tlast)
    else $error("single-result status without last");

  // Nothing comes out right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind xor_distance_bucket_table xdbt_checker u_xdbt_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the XOR distance bucket table. A behavioral copy of
// the bucket table predicts every reply of each accepted request. Directed
// cases cover own-ID, empty, partial, full and matching buckets at the edge
// buckets. Random traffic aimed at chosen buckets follows, under several
// local IDs, with random gaps on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import xdbt_pkg::*;

  localparam int Slots      = 3;
  localparam int Buckets    = 64;
  localparam int DrainWait  = 40;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;

  typedef struct {
    status_t        status;
    logic [5:0]     bkt;
    logic [IdW-1:0] entry;
    logic           last;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IdW-1:0]      in_tdata = '0;
  logic [0:0]          in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [StatusW-1:0]  out_tuser;
  logic                out_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IdW-1:0]      cfg_data = '0;

  // Mirror of the table and the local ID
  logic [IdW-1:0] local_node_id = '0;
  logic [IdW-1:0] bucket_ids [Buckets][Slots];
  int             bucket_fill [Buckets];
  reply_t         table_replies [$];

  int  err_count = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  int  hold_asks = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  ready_pause = 0;

  xor_distance_bucket_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [63:0] node_id
    .in_tuser   (in_tuser),   // [0] opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [5:0] bucket_index, [69:6] entry_id
    .out_tuser  (out_tuser),  // [2:0] status
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Leading zeros of a nonzero distance
  function automatic int lead_zero_count(input logic [IdW-1:0] d);
    int n;
    n = 0;
    for (int b = IdW - 1; b >= 0; b--) begin
      if (d[b]) break;
      n++;
    end
    return n;
  endfunction

  task automatic push_reply(input status_t st, input int bkt, input logic [IdW-1:0] id,
                            input logic last);
    reply_t r;
    r.status = st;
    r.bkt    = bkt[5:0];
    r.entry  = id;
    r.last   = last;
    table_replies.push_back(r);
  endtask

  // Apply one request to the mirror table and queue its replies
  task automatic apply_table_op(input opcode_t op, input logic [IdW-1:0] id);
    logic [IdW-1:0] xor_dist;
    int bkt;
    int cnt;
    bit hit;
    xor_dist = id ^ local_node_id;
    if (xor_dist == '0) begin
      push_reply(ST_OWN_ID, 0, '0, 1'b1);
      return;
    end
    bkt = lead_zero_count(xor_dist);
    cnt = bucket_fill[bkt];
    if (op == OP_INSERT) begin
      if (cnt < Slots) begin
        bucket_ids[bkt][cnt] = id;
        bucket_fill[bkt] = cnt + 1;
        push_reply(ST_INSERTED, bkt, '0, 1'b1);
      end else begin
        push_reply(ST_FULL, bkt, '0, 1'b1);
      end
    end else if (cnt == 0) begin
      push_reply(ST_EMPTY, bkt, '0, 1'b1);
    end else begin
      hit = 1'b0;
      for (int i = 0; i < cnt; i++)
        if (bucket_ids[bkt][i] == id) hit = 1'b1;
      if (hit) begin
        push_reply(ST_MATCH, bkt, id, 1'b1);
      end else begin
        // newest first, last flag on the oldest
        for (int i = cnt - 1; i >= 0; i--)
          push_reply(ST_ENTRY, bkt, bucket_ids[bkt][i], i == 0);
      end
    end
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_reply();
    reply_t r;
    if (table_replies.size() == 0) begin
      flag_error($sformatf("unexpected result status=%0d data=%h", out_tuser, out_tdata));
      return;
    end
    r = table_replies.pop_front();
    if (out_tuser !== r.status)
      flag_error($sformatf("status %0d, want %s", out_tuser, r.status.name()));
    if (out_tdata[5:0] !== r.bkt)
      flag_error($sformatf("bucket_index %0d, want %0d", out_tdata[5:0], r.bkt));
    if (out_tdata[69:6] !== r.entry)
      flag_error($sformatf("entry_id %h, want %h", out_tdata[69:6], r.entry));
    if (out_tlast !== r.last)
      flag_error($sformatf("tlast %b, want %b", out_tlast, r.last));
  endtask

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) check_reply();

  // Result receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles - 1;
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else if (ready_pause > 0) begin
      out_tready <= 1'b0;
      ready_pause--;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < 35) ready_pause = pick_gap();
    end
  end

  // Offer one request and hold it until accepted; valid stays high afterward
  task automatic send_req(input opcode_t op, input logic [IdW-1:0] id);
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_table_op(op, id);
  endtask

  task automatic sender_gap();
    int g;
    if (no_idle || $urandom_range(0, 99) < 40) return;
    g = pick_gap();
    in_tvalid <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  task automatic send_gapped(input opcode_t op, input logic [IdW-1:0] id);
    send_req(op, id);
    sender_gap();
  endtask

  // Wait for every predicted result, then for the block to settle
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_local_id(input logic [IdW-1:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    local_node_id = v;
  endtask

  // Random request: mostly aimed at chosen buckets, some noise and own ID
  task automatic pick_request(output opcode_t op, output logic [IdW-1:0] id);
    int r;
    int bkt;
    logic [IdW-1:0] top;
    r   = $urandom_range(0, 99);
    bkt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7) * 9;
    op  = opcode_t'($urandom_range(0, 1));
    top = 64'd1 << (63 - bkt);
    if (r < 5)
      id = local_node_id;
    else if (r < 15)
      id = {$urandom, $urandom};
    else if (op == OP_FIND && bucket_fill[bkt] != 0 && r < 50)
      id = bucket_ids[bkt][$urandom_range(0, bucket_fill[bkt] - 1)];
    else
      id = local_node_id ^ (top | ({$urandom, $urandom} & (top - 64'd1)));
  endtask

  // Edge buckets under the reset local ID of zero
  task automatic test_directed_buckets();
    send_gapped(OP_FIND,   64'h8000_0000_0000_0000);  // empty bucket
    send_gapped(OP_INSERT, 64'h0);                    // own ID
    send_gapped(OP_FIND,   64'h0);
    send_gapped(OP_INSERT, 64'h1);                    // deepest bucket
    send_gapped(OP_FIND,   64'h1);
    send_gapped(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_gapped(OP_INSERT, 64'h8000_0000_0000_0001);
    send_gapped(OP_FIND,   64'h8000_0000_0000_0000);  // partly filled, no match
    send_gapped(OP_INSERT, 64'hC000_0000_0000_0000);
    send_gapped(OP_INSERT, 64'hA000_0000_0000_0000);  // full, dropped
    send_gapped(OP_FIND,   64'h8000_0000_0000_0000);  // all three entries
    send_gapped(OP_FIND,   64'hFFFF_FFFF_FFFF_FFFF);  // match
    send_gapped(OP_INSERT, 64'h2);
    send_gapped(OP_INSERT, 64'h2);                    // duplicate kept
    send_gapped(OP_FIND,   64'h3);
    send_gapped(OP_FIND,   64'h2);
    send_gapped(OP_FIND,   64'h0000_0000_8000_0000);
    send_gapped(OP_INSERT, 64'h0000_0000_FFFF_FFFF);
    send_gapped(OP_FIND,   64'h0000_0000_8000_0000);  // single entry
  endtask

  // Local ID at all ones: own ID and stored entries seen from the other end
  task automatic test_local_all_ones();
    write_local_id('1);
    send_gapped(OP_FIND,   64'hFFFF_FFFF_FFFF_FFFF);
    send_gapped(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_gapped(OP_INSERT, 64'h0);
    send_gapped(OP_FIND,   64'h0);
    send_gapped(OP_FIND,   64'hFFFF_FFFF_FFFF_FFFE);
    send_gapped(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_random_traffic(input int per_phase);
    opcode_t op;
    logic [IdW-1:0] id;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       write_local_id('0);
        2:       write_local_id('1);
        default: write_local_id({$urandom, $urandom});
      endcase
      repeat (per_phase) begin
        pick_request(op, id);
        send_gapped(op, id);
      end
    end
  endtask

  // Long output hold-off while requests keep coming back to back
  task automatic test_output_backpressure(input int n);
    opcode_t op;
    logic [IdW-1:0] id;
    wait_drain();
    hold_asks++;
    repeat (n) begin
      pick_request(op, id);
      send_req(op, id);
    end
    wait_drain();
  endtask

  task automatic test_streaming(input int n);
    opcode_t op;
    logic [IdW-1:0] id;
    no_idle = 1'b1;
    repeat (n) begin
      pick_request(op, id);
      send_gapped(op, id);
    end
    wait_drain();
    no_idle = 1'b0;
  endtask

  initial begin
    for (int b = 0; b < Buckets; b++) bucket_fill[b] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_buckets();
    test_local_all_ones();
    test_random_traffic(20);
    test_output_backpressure(24);
    test_streaming(20);

    wait_drain();
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== xor_distance_bucket_table.f =====
sv/xdbt_pkg.sv
sv/xdbt_lzc.sv
sv/xdbt_store.sv
sv/xor_distance_bucket_table.sv
sv/xdbt_checker.sv
bench/tb.sv
